### rtl/cap_pkg.sv
// Shared types and constants for the constant-acceleration position predictor.
package cap_pkg;
  localparam int PosW = 32;
  localparam int VelW = 48;
  localparam int DtW  = 32;
  localparam int NumAxes = 3;
  // dividend is |dp| << 28, |dp| < 2^33
  localparam int DivW = 61;
  localparam logic signed [PosW-1:0] ResetPosX = 32'sh00000000;
  localparam logic signed [PosW-1:0] ResetPosY = 32'sh00140000;
  localparam logic signed [PosW-1:0] ResetPosZ = 32'shFF6A0000;

  typedef struct packed {
    logic start;
    logic zero;
  } lane_ctl_t;

  typedef struct packed {
    logic done;
    logic clip;
  } lane_sts_t;
endpackage

### rtl/cap_if.sv
// Valid/ready channel interfaces for the predictor.
interface cap_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [31:0] delta_time;
  modport source (output valid, pos_x, pos_y, pos_z, delta_time, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, delta_time, output ready);
endinterface

interface cap_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pred_x;
  logic signed [31:0] pred_y;
  logic signed [31:0] pred_z;
  logic zero_time;
  logic clipped;
  modport source (output valid, pred_x, pred_y, pred_z, zero_time, clipped, input ready);
  modport sink (input valid, pred_x, pred_y, pred_z, zero_time, clipped, output ready);
endinterface

### rtl/cap_lane.sv
// One axis lane: restoring divider for velocity, then split multiply for prediction.
module cap_lane
  import cap_pkg::*;
#(
  parameter logic signed [PosW-1:0] ResetPos = '0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lane_ctl_t              ctl,
  input  logic signed [PosW-1:0] pos,
  input  logic [DtW-1:0]         dt,
  output lane_sts_t              sts,
  output logic signed [PosW-1:0] pred
);
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_SAT, S_MUL_LO, S_MUL_HI, S_SUM} state_t;
  state_t state;

  logic signed [PosW-1:0] last_pos;
  logic signed [VelW-1:0] last_vel;
  logic signed [PosW-1:0] cur_pos;
  logic [DtW-1:0]         dt_r;
  logic                   neg;
  logic [DivW-1:0]        quot;
  logic [DtW:0]           rem;
  logic [5:0]             cnt;
  logic [50:0]            smag;
  logic                   sneg;
  logic [63:0]            plo;
  logic [49:0]            phi;

  logic signed [PosW:0]   dp;
  logic [PosW:0]          dp_mag;
  logic [DtW:0]           rem_sh;
  logic [DtW:0]           rem_sub;
  logic [VelW-1:0]        vel_sat;
  logic                   vel_clip;
  logic signed [VelW+2:0] s_val;
  logic [51:0]            r_mag;
  logic signed [53:0]     sum;

  assign dp     = {pos[PosW-1], pos} - {last_pos[PosW-1], last_pos};
  assign dp_mag = dp[PosW] ? (~dp + 1'b1) : dp;
  assign rem_sh = {rem[DtW-1:0], quot[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, dt_r};

  // clamp magnitude to the Q32.16 range, signed by the position change
  always_comb begin
    vel_clip = 1'b0;
    vel_sat = quot[VelW-1:0];
    if (!neg && quot > 61'h7FFF_FFFF_FFFF) begin
      vel_sat = 48'h7FFF_FFFF_FFFF;
      vel_clip = 1'b1;
    end else if (neg && quot > 61'h8000_0000_0000) begin
      vel_sat = 48'h8000_0000_0000;
      vel_clip = 1'b1;
    end
    if (neg) vel_sat = ~vel_sat + 1'b1;
  end

  assign s_val = 3 * {{3{vel_sat[VelW-1]}}, vel_sat} - {{3{last_vel[VelW-1]}}, last_vel};
  // the magnitude stays below 2^52
  assign r_mag = 52'({phi, 3'b000}) + 52'(plo[63:29]);
  assign sum = {{22{cur_pos[PosW-1]}}, cur_pos} + (sneg ? -$signed({2'b00, r_mag}) :
                                                        $signed({2'b00, r_mag}));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      last_pos <= ResetPos;
      last_vel <= '0;
      sts      <= '0;
    end else begin
      sts.done <= (state == S_SUM) || (state == S_IDLE && ctl.start && ctl.zero);
      case (state)
        S_IDLE: begin
          if (ctl.start) begin
            cur_pos <= pos;
            dt_r    <= dt;
            sts.clip <= 1'b0;
            if (ctl.zero) begin
              pred     <= pos;
              last_pos <= pos;
              last_vel <= '0;
            end else begin
              neg   <= dp[PosW];
              quot  <= {dp_mag, 28'd0};
              rem   <= '0;
              cnt   <= '0;
              state <= S_DIV;
            end
          end
        end
        // one quotient bit per cycle
        S_DIV: begin
          if (rem_sub[DtW] == 1'b0) begin
            rem  <= rem_sub;
            quot <= {quot[DivW-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            quot <= {quot[DivW-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'(DivW - 1)) state <= S_SAT;
        end
        S_SAT: begin
          sts.clip <= vel_clip;
          sneg     <= s_val[VelW+2];
          smag     <= s_val[VelW+2] ? 51'(-s_val) : 51'(s_val);
          last_vel <= vel_sat;
          last_pos <= cur_pos;
          state    <= S_MUL_LO;
        end
        S_MUL_LO: begin
          plo   <= 64'(smag[31:0]) * 64'(dt_r) + 64'h1000_0000;
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          phi   <= 50'(smag[50:32]) * 50'(dt_r);
          state <= S_SUM;
        end
        S_SUM: begin
          if (sum > 54'sh7FFF_FFFF) begin
            pred <= 32'sh7FFF_FFFF;
            sts.clip <= 1'b1;
          end else if (sum < -54'sh8000_0000) begin
            pred <= 32'sh8000_0000;
            sts.clip <= 1'b1;
          end else begin
            pred <= sum[PosW-1:0];
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/cap_merge.sv
// Merge stage: collects the three lanes into one output transaction.
module cap_merge
  import cap_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  lane_sts_t              sts_x,
  input  lane_sts_t              sts_y,
  input  lane_sts_t              sts_z,
  input  logic signed [PosW-1:0] px,
  input  logic signed [PosW-1:0] py,
  input  logic signed [PosW-1:0] pz,
  input  logic                   zero,
  cap_out_if.source              out,
  output logic                   busy
);
  // lanes run in lockstep, so x done marks all done
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      if (sts_x.done) begin
        out.valid     <= 1'b1;
        out.pred_x    <= px;
        out.pred_y    <= py;
        out.pred_z    <= pz;
        out.zero_time <= zero;
        out.clipped   <= sts_x.clip | sts_y.clip | sts_z.clip;
      end else if (out.ready) begin
        out.valid <= 1'b0;
      end
    end
  end
  assign busy = out.valid;
endmodule

### rtl/constant_accel_position_predictor.sv
// Top level of the constant-acceleration position predictor.
// Usage:
//  - in: one transaction carries pos_x/pos_y/pos_z (Q16.16) and delta_time (Q4.28).
//  - out: one transaction per input with pred_x/y/z (Q16.16, saturated),
//    zero_time and clipped.
//  - Three axis lanes run in lockstep; each divides (|dp| << 28) by delta_time
//    with a restoring divider, one quotient bit per cycle, then saturates,
//    and forms the prediction with two 32x32-or-narrower multiplies and a
//    saturating add.
//  - Order: divider loop, saturate, low and high multiply, sum, then the
//    registered done flag and output register; with delta_time zero the input
//    position is the prediction directly. One item in flight at a time: a new
//    item is not accepted until the last one is done.
//  - The divider loop sets the rate.
//  - Reset: last positions load (0, 20, -150), last velocities clear,
//    output valid drops, input ready stays low.
//  - Stall: the result holds in the output register until taken; a new
//    transaction is not accepted until the output register is empty.
module constant_accel_position_predictor
  import cap_pkg::*;
(
  input logic       clk,
  input logic       rst,
  cap_in_if.sink    in,
  cap_out_if.source out
);
  lane_ctl_t ctl;
  lane_sts_t sts_x, sts_y, sts_z;
  logic signed [PosW-1:0] px, py, pz;
  logic busy;
  logic out_busy;
  logic zero;

  assign in.ready = !rst && !busy && !out_busy;
  assign ctl.start = in.valid && in.ready;
  assign ctl.zero  = (in.delta_time == '0);

  // track one transaction in flight until a lane reports done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      zero <= ctl.zero;
    end else if (sts_x.done) begin
      busy <= 1'b0;
    end
  end

  cap_lane #(.ResetPos(ResetPosX)) u_lane_x (
    .clk, .rst, .ctl, .pos(in.pos_x), .dt(in.delta_time), .sts(sts_x), .pred(px)
  );
  cap_lane #(.ResetPos(ResetPosY)) u_lane_y (
    .clk, .rst, .ctl, .pos(in.pos_y), .dt(in.delta_time), .sts(sts_y), .pred(py)
  );
  cap_lane #(.ResetPos(ResetPosZ)) u_lane_z (
    .clk, .rst, .ctl, .pos(in.pos_z), .dt(in.delta_time), .sts(sts_z), .pred(pz)
  );

  cap_merge u_merge (
    .clk, .rst, .sts_x, .sts_y, .sts_z, .px, .py, .pz, .zero, .out, .busy(out_busy)
  );
endmodule
